>>> rtl/core/getrp_pkg.sv
// Package for the graph edge table risk propagation block.
// Holds opcodes, status codes, register indexes and the sequencer state type.
package getrp_pkg;

  localparam int unsigned IdW   = 16;
  localparam int unsigned RiskW = 8;
  localparam int unsigned TypeW = 4;
  localparam logic [7:0] DecayReset = 8'd15;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_LOAD  = 3'd1,
    OP_ADD   = 3'd2,
    OP_DEL   = 3'd3,
    OP_DEG   = 3'd4,
    OP_NBR   = 3'd5,
    OP_PROP  = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_SELF    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_BAD_IDX = 3'd4
  } status_e;

  localparam logic [0:0] REG_DECAY = 1'b0;
  localparam logic [0:0] REG_MASK  = 1'b1;

  // One-hot sequencer states.
  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_FIND   = 11'b000_0000_0010, // node search (load / add edge endpoints)
    S_DEL    = 11'b000_0000_0100, // edge shift down
    S_SCAN   = 11'b000_0000_1000, // degree / neighbour walk
    S_COPY   = 11'b000_0001_0000, // base risk to working risk
    S_ELOOK  = 11'b000_0010_0000, // read edge, start endpoint search
    S_EFIND  = 11'b000_0100_0000, // endpoint search
    S_RELAX  = 11'b000_1000_0000, // read working risks
    S_RWRITE = 11'b001_0000_0000, // compare and update
    S_EMIT   = 11'b010_0000_0000, // node risk output
    S_OUT    = 11'b100_0000_0000  // not entered; each state waits for the output slot itself
  } state_e;

  typedef struct packed {
    logic [IdW-1:0] value;
    status_e        status;
    logic           last;
  } result_t;

endpackage

>>> rtl/core/graph_edge_table_risk_propagation_top.sv
// Graph edge table with iterative risk propagation; depends on getrp_pkg and getrp_out_reg.
// One shared compare unit searches the node table; a one-hot sequencer walks the memories.
// One command at a time: input stalls while busy, pushing, or with the output full.
// Reset clears the node and edge counts, the mask and output valid, and sets decay to 15;
// tables are undefined until written.
module graph_edge_table_risk_propagation_top #(
  parameter int unsigned MAX_NODES = 32,
  parameter int unsigned MAX_EDGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:2]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [15:0] first_id_i,
  input  logic [15:0] second_id_i,
  input  logic [3:0]  edge_type_i,
  input  logic [7:0]  node_risk_i,
  input  logic [5:0]  edge_index_i,
  input  logic [5:0]  neighbour_cap_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] result_value_o,
  output logic [2:0]  status_o,
  output logic        last_o
);
  import getrp_pkg::*;

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned NCW = $clog2(MAX_NODES + 1);
  localparam int unsigned EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);

  // config registers
  logic [7:0]  decay_q;
  logic [15:0] mask_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DecayReset;
      mask_q  <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_DECAY) decay_q <= pwdata[7:0];
      else mask_q <= pwdata[15:0];
    end
  end
  assign prdata = (paddr[2] == REG_DECAY) ? {24'd0, decay_q} : {16'd0, mask_q};

  // memories
  logic [IdW-1:0]   nid_mem [MAX_NODES];
  logic [RiskW-1:0] base_mem [MAX_NODES];
  logic [RiskW-1:0] work_mem [MAX_NODES];
  logic [IdW-1:0]   esrc_mem [MAX_EDGES];
  logic [IdW-1:0]   etgt_mem [MAX_EDGES];
  logic [TypeW-1:0] ekind_mem [MAX_EDGES];

  state_e state_q, state_d;
  op_e    op_q;
  logic [IdW-1:0] a_q, b_q;
  logic [TypeW-1:0] typ_q;
  logic [RiskW-1:0] risk_q;
  logic [5:0] cap_q;
  logic [NCW-1:0] ncnt_q;
  logic [ECW-1:0] ecnt_q;
  logic [NCW-1:0] ni_q;     // node scan index
  logic [ECW-1:0] ei_q;     // edge scan index
  logic [NCW-1:0] pass_q;
  logic changed_q;
  logic [IdW-1:0] key_q;     // id being searched
  logic [NCW-1:0] hit_q;     // last hit index
  logic hit_v_q;
  logic phase_q;           // 0 first endpoint, 1 second
  logic [NCW-1:0] s_idx_q;
  logic s_ok_q;
  logic [15:0] cnt_q;
  logic [IdW-1:0] etgt_rd_q;
  logic [RiskW-1:0] src_r_q, tgt_r_q;
  logic [NW-1:0] tslot_q;

  // shared compare unit: node table id against search key
  logic key_eq;
  logic [NW-1:0] nidx;
  logic [EW-1:0] eidx;
  assign nidx   = ni_q[NW-1:0];
  assign eidx   = ei_q[EW-1:0];
  assign key_eq = (nid_mem[nidx] == key_q);

  // registered edge read port; delete reads the entry above the one it writes
  logic [EW-1:0]    erd_addr;
  logic [IdW-1:0]   erd_src_q, erd_tgt_q;
  logic [TypeW-1:0] erd_kind_q;
  logic             erd_v_q;   // read data belongs to ei_q
  assign erd_addr = (state_q == S_DEL) ? EW'(ei_q + 1'b1) : eidx;
  always_ff @(posedge clk_i) begin
    erd_src_q  <= esrc_mem[erd_addr];
    erd_tgt_q  <= etgt_mem[erd_addr];
    erd_kind_q <= ekind_mem[erd_addr];
  end

  logic out_push, out_full;
  result_t out_word;
  result_t out_q;

  getrp_out_reg u_out (
    .clk_i, .rst_ni,
    .push_i (out_push), .word_i (out_word), .full_o (out_full),
    .valid_o (out_valid_o), .stall_i (out_stall_i), .word_o (out_q)
  );
  assign result_value_o = out_q.value;
  assign status_o       = out_q.status;
  assign last_o         = out_q.last;

  assign in_stall_o = (state_q != S_IDLE) || out_full || out_push;
  logic accept;
  assign accept = in_valid_i && !in_stall_o;

  // single clocked sequencer; node and edge scans step through their tables one entry at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ncnt_q  <= '0;
      ecnt_q  <= '0;
      out_push <= 1'b0;
    end else begin : seq_body
      logic push;
      push = 1'b0;
      case (state_q)
        S_IDLE: if (accept) begin
          op_q <= op_e'(op_i); a_q <= first_id_i; b_q <= second_id_i;
          typ_q <= edge_type_i; risk_q <= node_risk_i; cap_q <= neighbour_cap_i;
          ni_q <= '0; cnt_q <= '0; hit_v_q <= 1'b0;
          ei_q <= (op_e'(op_i) == OP_DEL) ? ECW'(edge_index_i) : '0;
          erd_v_q <= 1'b0;
          phase_q <= 1'b0; key_q <= first_id_i;
          case (op_e'(op_i))
            OP_CLEAR: begin
              ncnt_q <= '0; ecnt_q <= '0;
              push = 1'b1; out_word <= '{16'd0, ST_OK, 1'b1};
            end
            OP_LOAD: state_q <= S_FIND;
            OP_ADD: begin
              if (ecnt_q >= ECW'(MAX_EDGES)) begin
                push = 1'b1; out_word <= '{16'd0, ST_FULL, 1'b1};
              end else if (first_id_i == second_id_i) begin
                push = 1'b1; out_word <= '{16'd0, ST_SELF, 1'b1};
              end else state_q <= S_FIND;
            end
            OP_DEL: begin
              if (ECW'(edge_index_i) >= ecnt_q) begin
                push = 1'b1; out_word <= '{16'd0, ST_BAD_IDX, 1'b1};
              end else begin
                state_q <= S_DEL;
              end
            end
            OP_DEG, OP_NBR: state_q <= S_SCAN;
            OP_PROP: begin
              if (ncnt_q == '0) begin
                push = 1'b1; out_word <= '{16'd0, ST_OK, 1'b1};
              end else state_q <= S_COPY;
            end
            default: ;
          endcase
        end
        S_FIND: begin
          if (ni_q < ncnt_q) begin
            if (key_eq) begin hit_v_q <= 1'b1; hit_q <= ni_q; end
            ni_q <= ni_q + 1'b1;
          end else if (out_full) begin
            // hold until the output slot frees up
          end else if (op_q == OP_LOAD) begin
            state_q <= S_IDLE; push = 1'b1;
            if (hit_v_q) begin
              base_mem[hit_q[NW-1:0]] <= risk_q;
              out_word <= '{16'(hit_q), ST_OK, 1'b1};
            end else if (ncnt_q >= NCW'(MAX_NODES)) begin
              out_word <= '{16'd0, ST_FULL, 1'b1};
            end else begin
              nid_mem[ncnt_q[NW-1:0]]  <= a_q;
              base_mem[ncnt_q[NW-1:0]] <= risk_q;
              out_word <= '{16'(ncnt_q), ST_OK, 1'b1};
              ncnt_q <= ncnt_q + 1'b1;
            end
          end else if (!hit_v_q) begin
            state_q <= S_IDLE; push = 1'b1;
            out_word <= '{16'd0, ST_UNKNOWN, 1'b1};
          end else if (!phase_q) begin
            phase_q <= 1'b1; key_q <= b_q; ni_q <= '0; hit_v_q <= 1'b0;
          end else begin
            esrc_mem[ecnt_q[EW-1:0]]  <= a_q;
            etgt_mem[ecnt_q[EW-1:0]]  <= b_q;
            ekind_mem[ecnt_q[EW-1:0]] <= typ_q;
            ecnt_q <= ecnt_q + 1'b1;
            state_q <= S_IDLE; push = 1'b1;
            out_word <= '{16'(ecnt_q), ST_OK, 1'b1};
          end
        end
        S_DEL: begin
          if (ei_q + 1'b1 < ecnt_q) begin
            if (!erd_v_q) erd_v_q <= 1'b1;
            else begin
              esrc_mem[eidx]  <= erd_src_q;
              etgt_mem[eidx]  <= erd_tgt_q;
              ekind_mem[eidx] <= erd_kind_q;
              ei_q <= ei_q + 1'b1;
              erd_v_q <= 1'b0;
            end
          end else if (!out_full) begin
            ecnt_q <= ecnt_q - 1'b1;
            state_q <= S_IDLE; push = 1'b1;
            out_word <= '{16'd0, ST_OK, 1'b1};
          end
        end
        S_SCAN: if (!out_full && !out_push) begin
          if (ei_q < ecnt_q && (op_q == OP_DEG || cnt_q < 16'(cap_q))) begin
            if (!erd_v_q) erd_v_q <= 1'b1;
            else begin
              ei_q <= ei_q + 1'b1;
              erd_v_q <= 1'b0;
              if (op_q == OP_DEG) begin
                if (erd_src_q == a_q || erd_tgt_q == a_q) cnt_q <= cnt_q + 1'b1;
              end else if (erd_src_q == a_q) begin
                cnt_q <= cnt_q + 1'b1; push = 1'b1;
                out_word <= '{erd_tgt_q, ST_OK, 1'b0};
              end
            end
          end else begin
            state_q <= S_IDLE; push = 1'b1;
            out_word <= '{cnt_q, ST_OK, 1'b1};
          end
        end
        S_COPY: begin
          if (ni_q < ncnt_q) begin
            work_mem[nidx] <= base_mem[nidx];
            ni_q <= ni_q + 1'b1;
          end else begin
            pass_q <= '0; changed_q <= 1'b0; ei_q <= '0; erd_v_q <= 1'b0;
            state_q <= S_ELOOK;
          end
        end
        S_ELOOK: begin
          if (ei_q < ecnt_q) begin
            if (!erd_v_q) erd_v_q <= 1'b1;
            else if (mask_q[erd_kind_q]) begin
              key_q <= erd_src_q; etgt_rd_q <= erd_tgt_q;
              ni_q <= '0; hit_v_q <= 1'b0; phase_q <= 1'b0;
              state_q <= S_EFIND;
            end else begin
              ei_q <= ei_q + 1'b1; erd_v_q <= 1'b0;
            end
          end else if (changed_q && pass_q + 1'b1 < ncnt_q) begin
            pass_q <= pass_q + 1'b1; changed_q <= 1'b0; ei_q <= '0; erd_v_q <= 1'b0;
          end else begin
            ni_q <= '0; state_q <= S_EMIT;
          end
        end
        S_EFIND: begin
          if (ni_q < ncnt_q) begin
            if (key_eq) begin hit_v_q <= 1'b1; hit_q <= ni_q; end
            ni_q <= ni_q + 1'b1;
          end else if (!hit_v_q) begin
            ei_q <= ei_q + 1'b1; erd_v_q <= 1'b0; state_q <= S_ELOOK;
          end else if (!phase_q) begin
            s_idx_q <= hit_q; phase_q <= 1'b1; key_q <= etgt_rd_q;
            ni_q <= '0; hit_v_q <= 1'b0;
          end else begin
            tslot_q <= hit_q[NW-1:0];
            state_q <= S_RELAX;
          end
        end
        S_RELAX: begin
          src_r_q <= work_mem[s_idx_q[NW-1:0]];
          tgt_r_q <= work_mem[tslot_q];
          state_q <= S_RWRITE;
        end
        S_RWRITE: begin
          if (src_r_q > decay_q && (src_r_q - decay_q) > tgt_r_q) begin
            work_mem[tslot_q] <= src_r_q - decay_q;
            changed_q <= 1'b1;
          end
          ei_q <= ei_q + 1'b1; erd_v_q <= 1'b0; state_q <= S_ELOOK;
        end
        S_EMIT: if (!out_full && !out_push) begin
          push = 1'b1;
          out_word <= '{16'(work_mem[nidx]), ST_OK, (ni_q + 1'b1 == ncnt_q)};
          ni_q <= ni_q + 1'b1;
          if (ni_q + 1'b1 == ncnt_q) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      out_push <= push;
    end
  end
endmodule

>>> rtl/core/getrp_out_reg.sv
// Output register for result words; parts the sequencer from the consumer.
// Depends on getrp_pkg.
module getrp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  getrp_pkg::result_t word_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output getrp_pkg::result_t word_o
);
  import getrp_pkg::*;

  logic    valid_q, valid_d;
  result_t word_q;

  assign full_o  = valid_q && stall_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && !stall_i) valid_d = 1'b0;
    if (push_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) word_q <= word_i;
  end
endmodule

>>> tb/graph_edge_table_risk_propagation_top_test.sv
// Self-checking test of the graph edge table risk propagation block.
// Needs getrp_pkg and graph_edge_table_risk_propagation_top; predicts every result word.
module graph_edge_table_risk_propagation_top_test;
  import getrp_pkg::*;

  localparam int NNODE = 32;
  localparam int NEDGE = 64;
  localparam int IDLE_LIMIT = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:2]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  op_i = '0;
  logic [15:0] first_id_i = '0, second_id_i = '0;
  logic [3:0]  edge_type_i = '0;
  logic [7:0]  node_risk_i = '0;
  logic [5:0]  edge_index_i = '0, neighbour_cap_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] result_value_o;
  logic [2:0]  status_o;
  logic        last_o;

  graph_edge_table_risk_propagation_top dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  decay_q = DecayReset;
  logic [15:0] mask_q = '0;
  logic [15:0] g_id [NNODE];
  logic [7:0]  g_base [NNODE];
  int          g_nodes = 0;
  logic [15:0] g_src [NEDGE];
  logic [15:0] g_dst [NEDGE];
  logic [3:0]  g_kind [NEDGE];
  int          g_edges = 0;

  result_t     pending_words[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          gap_left = 0;
  int          stall_mode = 0;
  logic [15:0] pool[$];

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int locate(input logic [15:0] id);
    int hit;
    hit = -1;
    for (int i = 0; i < g_nodes; i++) if (g_id[i] == id) hit = i;
    return hit;
  endfunction

  function automatic result_t word(input int v, input status_e s, input logic l);
    result_t r;
    r.value = v[15:0];
    r.status = s;
    r.last = l;
    return r;
  endfunction

  task automatic predict(input op_e op, input logic [15:0] a, input logic [15:0] b,
                         input logic [3:0] typ, input logic [7:0] risk,
                         input logic [5:0] eidx, input logic [5:0] cap);
    int i, n, s, t, pass;
    bit changed;
    logic [7:0] w [NNODE];
    logic [7:0] inc;
    case (op)
      OP_CLEAR: begin
        g_nodes = 0;
        g_edges = 0;
        pending_words.push_back(word(0, ST_OK, 1));
      end
      OP_LOAD: begin
        i = locate(a);
        if (i >= 0) begin
          g_base[i] = risk;
          pending_words.push_back(word(i, ST_OK, 1));
        end else if (g_nodes >= NNODE) begin
          pending_words.push_back(word(0, ST_FULL, 1));
        end else begin
          g_id[g_nodes] = a;
          g_base[g_nodes] = risk;
          pending_words.push_back(word(g_nodes, ST_OK, 1));
          g_nodes++;
        end
      end
      OP_ADD: begin
        if (g_edges >= NEDGE) pending_words.push_back(word(0, ST_FULL, 1));
        else if (a == b) pending_words.push_back(word(0, ST_SELF, 1));
        else if (locate(a) < 0 || locate(b) < 0)
          pending_words.push_back(word(0, ST_UNKNOWN, 1));
        else begin
          g_src[g_edges] = a;
          g_dst[g_edges] = b;
          g_kind[g_edges] = typ;
          pending_words.push_back(word(g_edges, ST_OK, 1));
          g_edges++;
        end
      end
      OP_DEL: begin
        if (eidx >= g_edges) pending_words.push_back(word(0, ST_BAD_IDX, 1));
        else begin
          for (i = eidx; i + 1 < g_edges; i++) begin
            g_src[i] = g_src[i+1];
            g_dst[i] = g_dst[i+1];
            g_kind[i] = g_kind[i+1];
          end
          g_edges--;
          pending_words.push_back(word(0, ST_OK, 1));
        end
      end
      OP_DEG: begin
        n = 0;
        for (i = 0; i < g_edges; i++) if (g_src[i] == a || g_dst[i] == a) n++;
        pending_words.push_back(word(n, ST_OK, 1));
      end
      OP_NBR: begin
        n = 0;
        for (i = 0; i < g_edges && n < cap; i++)
          if (g_src[i] == a) begin
            pending_words.push_back(word(g_dst[i], ST_OK, 0));
            n++;
          end
        pending_words.push_back(word(n, ST_OK, 1));
      end
      OP_PROP: begin
        if (g_nodes == 0) pending_words.push_back(word(0, ST_OK, 1));
        else begin
          for (i = 0; i < g_nodes; i++) w[i] = g_base[i];
          for (pass = 0; pass < g_nodes; pass++) begin
            changed = 0;
            for (int e = 0; e < g_edges; e++) begin
              if (!mask_q[g_kind[e]]) continue;
              s = locate(g_src[e]);
              t = locate(g_dst[e]);
              if (s < 0 || t < 0) continue;
              inc = (w[s] > decay_q) ? w[s] - decay_q : 8'd0;
              if (inc > w[t]) begin
                w[t] = inc;
                changed = 1;
              end
            end
            if (!changed) break;
          end
          for (i = 0; i < g_nodes; i++)
            pending_words.push_back(word(w[i], ST_OK, i + 1 == g_nodes));
        end
      end
      default: ;
    endcase
  endtask

  // one command word; sender bursts with random gaps
  task automatic send_cmd(input op_e op, input logic [15:0] a = 0, input logic [15:0] b = 0,
                          input logic [3:0] typ = 0, input logic [7:0] risk = 0,
                          input logic [5:0] eidx = 0, input logic [5:0] cap = 0);
    @(posedge clk_i);
    if (gap_left == 0 && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 12);
    while (gap_left > 0) begin
      @(posedge clk_i);
      gap_left--;
    end
    op_i <= op;
    first_id_i <= a;
    second_id_i <= b;
    edge_type_i <= typ;
    node_risk_i <= risk;
    edge_index_i <= eidx;
    neighbour_cap_i <= cap;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict(op, a, b, typ, risk, eidx, cap);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input bit idx, input logic [31:0] v);
    paddr <= idx;
    pwdata <= v;
    pwrite <= 1'b1;
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_DECAY) decay_q = v[7:0];
    else mask_q = v[15:0];
    @(posedge clk_i);
  endtask

  // checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        report("unexpected word", result_value_o, 0);
      end else begin
        want = pending_words.pop_front();
        if (result_value_o !== want.value) report("value", result_value_o, want.value);
        if (status_o !== want.status) report("status", status_o, want.status);
        if (last_o !== want.last) report("last", last_o, want.last);
      end
    end
  end

  // receiver stall pattern: phases of none, light, heavy
  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("graph_edge_table_risk_propagation_top verification failed");
      $finish;
    end
  end

  function automatic logic [15:0] pick_id();
    if (pool.size() > 0 && $urandom_range(0, 9) != 0) return pool[$urandom_range(0, pool.size()-1)];
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    send_cmd(OP_PROP);
    send_cmd(OP_NBR, 16'h0, 0, 0, 0, 0, 6'd63);
    send_cmd(OP_LOAD, 16'h0000, 0, 0, 8'hFF);
    send_cmd(OP_LOAD, 16'hFFFF, 0, 0, 8'h00);
    send_cmd(OP_LOAD, 16'h0000, 0, 0, 8'hC8);
    send_cmd(OP_ADD, 16'h0000, 16'h0000, 4'hF);
    send_cmd(OP_ADD, 16'h0000, 16'h1234, 4'h0);
    send_cmd(OP_ADD, 16'h0000, 16'hFFFF, 4'hF);
    send_cmd(OP_ADD, 16'hFFFF, 16'h0000, 4'h0);
    send_cmd(OP_DEG, 16'h0000);
    send_cmd(OP_NBR, 16'h0000, 0, 0, 0, 0, 6'd0);
    send_cmd(OP_NBR, 16'h0000, 0, 0, 0, 0, 6'd63);
    send_cmd(OP_PROP);
    send_cmd(OP_DEL, 0, 0, 0, 0, 6'd63);
    send_cmd(OP_DEL, 0, 0, 0, 0, 6'd0);
    send_cmd(OP_NONE);
    send_cmd(OP_CLEAR);
    wait_drain();
  endtask

  task automatic test_full_tables();
    for (int i = 0; i < NNODE + 1; i++) send_cmd(OP_LOAD, 16'(i * 3 + 7), 0, 0, 8'(i * 8));
    for (int i = 0; i < NEDGE + 1; i++)
      send_cmd(OP_ADD, 16'((i % NNODE) * 3 + 7), 16'(((i + 1) % NNODE) * 3 + 7), 4'(i));
    send_cmd(OP_NBR, 16'd7, 0, 0, 0, 0, 6'd63);
    send_cmd(OP_PROP);
    wait_drain();
  endtask

  task automatic test_random(input int count);
    op_e op;
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      if (k < 2) op = OP_CLEAR;
      else if (k < 25) op = OP_LOAD;
      else if (k < 55) op = OP_ADD;
      else if (k < 65) op = OP_DEL;
      else if (k < 73) op = OP_DEG;
      else if (k < 83) op = OP_NBR;
      else op = OP_PROP;
      if (op == OP_CLEAR) pool.delete();
      if (op == OP_LOAD && pool.size() < 12) pool.push_back(16'($urandom));
      send_cmd(op, pick_id(), pick_id(), 4'($urandom_range(0, 15)), 8'($urandom),
               6'($urandom_range(0, 20)), 6'($urandom_range(0, 63)));
      if (op == OP_LOAD && pool.size() > 0) ;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_reg(REG_MASK, 32'hFFFF);
    write_reg(REG_DECAY, 32'd0);
    test_full_tables();
    send_cmd(OP_CLEAR);
    wait_drain();
    write_reg(REG_DECAY, 32'd255);
    test_random(40);
    wait_drain();
    write_reg(REG_DECAY, 32'd20);
    write_reg(REG_MASK, 32'h5A5A);
    test_random(80);
    wait_drain();
    write_reg(REG_DECAY, 32'd3);
    write_reg(REG_MASK, 32'h0000);
    test_random(20);
    wait_drain();
    write_reg(REG_MASK, 32'hFFFF);
    test_random(60);
    wait_drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_words.size() == 0)
      $display("graph_edge_table_risk_propagation_top verification clean");
    else
      $display("graph_edge_table_risk_propagation_top verification failed");
    $finish;
  end

endmodule

>>> graph_edge_table_risk_propagation_top.f
rtl/core/getrp_pkg.sv
rtl/core/getrp_out_reg.sv
rtl/core/graph_edge_table_risk_propagation_top.sv
tb/graph_edge_table_risk_propagation_top_test.sv
